/* sv/spq_pkg.sv */
package spq_pkg;

  localparam int EVENT_W = 16;
  localparam int PRIO_W  = 2;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  typedef struct packed {
    logic               action;
    logic [PRIO_W-1:0]  priority_req;
    logic [EVENT_W-1:0] event_value;
  } in_word_t;

  typedef struct packed {
    logic               ok;
    logic               bad_priority;
    logic [EVENT_W-1:0] out_value;
    logic [PRIO_W-1:0]  out_priority;
  } out_word_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

/* sv/spq_in_if.sv */
interface spq_in_if;
  import spq_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

/* sv/spq_out_if.sv */
interface spq_out_if;
  import spq_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

/* sv/strict_priority_event_queue.sv */
// channel   | role   | word
// ----------+--------+----------------------------------------------------
// in_ch     | sink   | action, priority_req, event_value
// out_ch    | source | ok, bad_priority, out_value, out_priority
//
// An enqueue, a rejected enqueue or a dequeue that finds every level empty
// loads its result word directly; a dequeue that finds an event first does a
// registered read of the event memory, then loads the result from it in ST_READ.
// Reset (rst, synchronous) puts heads and tails at the top index and clears the
// full flags; the event memory keeps its contents.
// A waiting result word stalls the input until taken, and may leave as a new word enters.
module strict_priority_event_queue #(
  parameter int NUM_LEVELS = 3,
  parameter int RING_DEPTH = 16
) (
  input logic      clk,
  input logic      rst,
  spq_in_if.sink   in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int MEM_D  = NUM_LEVELS * RING_DEPTH;
  localparam int ADDR_W = $clog2(MEM_D);
  localparam int CMP_W  = 4;
  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(RING_DEPTH - 1);

  logic [EVENT_W-1:0] mem [MEM_D];
  logic [EVENT_W-1:0] rd_data;

  logic [IDX_W-1:0] head [NUM_LEVELS];
  logic [IDX_W-1:0] tail [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] full;

  state_t state, state_next;
  logic [LVL_W-1:0] pend_lv;
  logic      out_valid;
  out_word_t out_word;

  logic in_ready, accept;
  logic prio_ok, enq_go, deq_go;
  logic [LVL_W-1:0] enq_lv, pick_lv;
  logic [NUM_LEVELS-1:0] nonempty;
  logic found;
  logic [IDX_W-1:0] tail_m, tail_step, head_m, head_step;
  logic wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic load_now;
  out_word_t now_word;
  logic full_mismatch;

  // Decode of the incoming word, pick of the highest non-empty level, ring addresses
  always_comb begin
    prio_ok = (in_ch.word.priority_req != '0) &&
              ({{(CMP_W-PRIO_W){1'b0}}, in_ch.word.priority_req} <= CMP_W'(NUM_LEVELS));
    enq_lv  = LVL_W'(PRIO_W'(in_ch.word.priority_req - PRIO_W'(1)));
    found   = 1'b0;
    pick_lv = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      nonempty[l] = (head[l] != tail[l]) || full[l];
      if (nonempty[l]) begin
        found   = 1'b1;
        pick_lv = LVL_W'(l);
      end
    end
    tail_m    = tail[enq_lv] & TOP_IDX;
    tail_step = (tail_m == '0) ? TOP_IDX : tail_m - IDX_W'(1);
    head_m    = head[pick_lv] & TOP_IDX;
    head_step = (head_m == '0) ? TOP_IDX : head_m - IDX_W'(1);
    wr_addr   = ADDR_W'(enq_lv) * ADDR_W'(RING_DEPTH) + ADDR_W'(tail_m);
    rd_addr   = ADDR_W'(pick_lv) * ADDR_W'(RING_DEPTH) + ADDR_W'(head_m);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && in_ch.word.action == ACT_DEQUEUE && found) state_next = ST_READ;
      end
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready = 1'b0;
    case (state)
      ST_IDLE: in_ready = !out_valid || out_ch.ready;
      ST_READ: in_ready = 1'b0;
      default: in_ready = 1'b0;
    endcase
    accept = in_ch.valid && in_ready;
    enq_go = accept && in_ch.word.action == ACT_ENQUEUE && prio_ok;
    deq_go = accept && in_ch.word.action == ACT_DEQUEUE && found;
    wr_en  = enq_go && !full[enq_lv];
    rd_en  = deq_go;
    // every accepted word but a successful dequeue answers at once
    load_now = accept && !deq_go;
    now_word = '0;
    if (in_ch.word.action == ACT_ENQUEUE) begin
      now_word.ok           = wr_en;
      now_word.bad_priority = !prio_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_ch.word.event_value;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      full  <= '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head[l] <= TOP_IDX;
        tail[l] <= TOP_IDX;
      end
    end else begin
      state <= state_next;
      if (wr_en) begin
        tail[enq_lv] <= tail_step;
        if (tail_step == head[enq_lv]) full[enq_lv] <= 1'b1;
      end
      if (rd_en) begin
        head[pick_lv] <= head_step;
        full[pick_lv] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) pend_lv <= pick_lv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_now || state == ST_READ) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_now) begin
      out_word <= now_word;
    end else if (state == ST_READ) begin
      out_word.ok           <= 1'b1;
      out_word.bad_priority <= 1'b0;
      out_word.out_value    <= rd_data;
      out_word.out_priority <= PRIO_W'({1'b0, pend_lv} + (LVL_W+1)'(1));
    end
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.word  = out_word;

  always_comb begin
    full_mismatch = 1'b0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (full[l] && head[l] != tail[l]) full_mismatch = 1'b1;
    end
  end

  a_read_no_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> !out_valid)
    else $error("result word pending while a memory read is in flight");

  a_read_follows: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> state == ST_READ && out_valid == 1'b0)
    else $error("memory read not followed by read state");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> out_valid && out_word.ok && !out_word.bad_priority)
    else $error("dequeue result not loaded after read");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full[enq_lv])
    else $error("write into a full level");

  a_full_ptrs: assert property (@(posedge clk) disable iff (rst)
    !full_mismatch)
    else $error("full flag set with head and tail apart");

endmodule

/* tb/spq_order_tracker.sv */
module spq_order_tracker #(
  parameter int NUM_LEVELS = 3,
  parameter int RING_DEPTH = 16
) (
  input logic clk,
  input logic rst,
  spq_in_if   in_ch,
  spq_out_if  out_ch,
  output int  error_count,
  output int  pending,
  output int  results_seen,
  output int  full_rejects,
  output int  empty_reads
);
  import spq_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);
  typedef logic [IDX_W-1:0] ring_idx_t;

  logic [EVENT_W-1:0] ring_mem [NUM_LEVELS][RING_DEPTH];
  ring_idx_t          head_ptr [NUM_LEVELS];
  ring_idx_t          tail_ptr [NUM_LEVELS];
  logic               full_bit [NUM_LEVELS];

  out_word_t due_results[$];
  out_word_t want;
  out_word_t got;

  int mismatches = 0;
  int checked    = 0;
  int refused    = 0;
  int dry_reads  = 0;

  assign error_count  = mismatches;
  assign pending      = due_results.size();
  assign results_seen = checked;
  assign full_rejects = refused;
  assign empty_reads  = dry_reads;

  function automatic ring_idx_t step_down(ring_idx_t idx);
    return (idx == 0) ? ring_idx_t'(RING_DEPTH - 1) : idx - 1'b1;
  endfunction

  // Apply one word to the queue state and return the result it should produce.
  function automatic out_word_t apply_request(in_word_t req);
    out_word_t res;
    int        lvl;
    int        k;
    logic      found;
    res = '0;
    found = 1'b0;
    if (req.action == ACT_ENQUEUE) begin
      if (req.priority_req == 0 || int'(req.priority_req) > NUM_LEVELS) begin
        res.bad_priority = 1'b1;
      end else begin
        lvl = int'(req.priority_req) - 1;
        if (full_bit[lvl]) begin
          refused++;
        end else begin
          ring_mem[lvl][tail_ptr[lvl]] = req.event_value;
          tail_ptr[lvl] = step_down(tail_ptr[lvl]);
          if (tail_ptr[lvl] == head_ptr[lvl]) full_bit[lvl] = 1'b1;
          res.ok = 1'b1;
        end
      end
    end else begin
      // scan from the highest level down; take the first one holding an event
      for (k = NUM_LEVELS; k > 0; k--) begin
        if (!found && (head_ptr[k-1] != tail_ptr[k-1] || full_bit[k-1])) begin
          found = 1'b1;
          res.ok = 1'b1;
          res.out_value = ring_mem[k-1][head_ptr[k-1]];
          res.out_priority = PRIO_W'(k);
          head_ptr[k-1] = step_down(head_ptr[k-1]);
          full_bit[k-1] = 1'b0;
        end
      end
      if (!found) dry_reads++;
    end
    return res;
  endfunction

  task automatic check_field(input string field, input logic [EVENT_W-1:0] exp_v,
                             input logic [EVENT_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %h, got %h", $time, field, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_ptr[i] = ring_idx_t'(RING_DEPTH - 1);
        tail_ptr[i] = ring_idx_t'(RING_DEPTH - 1);
        full_bit[i] = 1'b0;
      end
      due_results.delete();
    end else begin
      // compare first: a result leaving now never belongs to a word entering now
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.word;
        if (due_results.size() == 0) begin
          $display("%0t: no result expected, got ok=%b bad=%b value=%h level=%0d",
                   $time, got.ok, got.bad_priority, got.out_value, got.out_priority);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          checked++;
          check_field("ok", EVENT_W'(want.ok), EVENT_W'(got.ok));
          check_field("bad_priority", EVENT_W'(want.bad_priority), EVENT_W'(got.bad_priority));
          check_field("out_value", want.out_value, got.out_value);
          check_field("out_priority", EVENT_W'(want.out_priority), EVENT_W'(got.out_priority));
        end
      end
      if (in_ch.valid && in_ch.ready) due_results.push_back(apply_request(in_ch.word));
    end
  end

endmodule

/* tb/tb_strict_priority_event_queue.sv */
module tb_strict_priority_event_queue;
  import spq_pkg::*;

  localparam int ITEM_TARGET = 1950;
  localparam int IDLE_PCT    = 17;
  localparam int HOLD_CYCLES = 60;

  logic clk;
  logic rst;

  spq_in_if  in_ch();
  spq_out_if out_ch();

  int error_count;
  int pending;
  int results_seen;
  int full_rejects;
  int empty_reads;

  bit calm          = 1'b0;
  int hold_requests = 0;
  int words_sent    = 0;
  int enqueues      = 0;
  int dequeues      = 0;
  int bad_levels    = 0;

  strict_priority_event_queue uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  spq_order_tracker tracker (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .error_count  (error_count),
    .pending      (pending),
    .results_seen (results_seen),
    .full_rejects (full_rejects),
    .empty_reads  (empty_reads)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("FAIL strict_priority_event_queue");
    $finish;
  end

  // Result side: random stalls, plus a long hold whenever one is requested.
  initial begin
    int hold_served;
    hold_served = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_served++;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic act, input logic [PRIO_W-1:0] lvl,
                           input logic [EVENT_W-1:0] value);
    in_word_t w;
    w.action = act;
    w.priority_req = lvl;
    w.event_value = value;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.word <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
    if (act == ACT_DEQUEUE) dequeues++;
    else if (lvl == 0) bad_levels++;
    else enqueues++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  initial begin
    int kind;
    int lvl;
    int n;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.word = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed: empty read, bad level, value extremes, priority order, wrap to empty
    send_word(ACT_DEQUEUE, 2'd3, 16'hFFFF);
    send_word(ACT_ENQUEUE, 2'd0, 16'hFFFF);
    send_word(ACT_ENQUEUE, 2'd1, 16'h0000);
    send_word(ACT_ENQUEUE, 2'd1, 16'hFFFF);
    send_word(ACT_ENQUEUE, 2'd2, 16'h8001);
    send_word(ACT_ENQUEUE, 2'd3, 16'hFFFF);
    send_word(ACT_ENQUEUE, 2'd3, 16'h0000);
    send_word(ACT_DEQUEUE, 2'd0, 16'h0000);
    send_word(ACT_ENQUEUE, 2'd2, 16'h7FFE);
    send_word(ACT_DEQUEUE, 2'd1, 16'h5555);
    send_word(ACT_DEQUEUE, 2'd2, 16'hAAAA);
    send_word(ACT_DEQUEUE, 2'd3, 16'h0000);
    send_word(ACT_DEQUEUE, 2'd0, 16'hFFFF);
    send_word(ACT_ENQUEUE, 2'd3, 16'h5A5A);
    send_word(ACT_DEQUEUE, 2'd0, 16'h0000);
    send_word(ACT_DEQUEUE, 2'd0, 16'h0000);
    send_word(ACT_DEQUEUE, 2'd0, 16'h0000);
    send_word(ACT_DEQUEUE, 2'd1, 16'hAAAA);
    drain_results();

    // hold the result side while a full ring's worth and more is offered
    hold_requests++;
    repeat (20) send_word(ACT_ENQUEUE, 2'd2, 16'($urandom));
    drain_results();

    while (words_sent < ITEM_TARGET) begin
      calm = (words_sent >= 700 && words_sent < 1000);
      kind = $urandom_range(9);
      if (kind < 3) begin
        lvl = $urandom_range(1, 3);
        n = $urandom_range(4, 20);
        repeat (n) send_word(ACT_ENQUEUE, 2'(lvl), 16'($urandom));
      end else if (kind < 5) begin
        n = $urandom_range(4, 40);
        repeat (n) send_word(ACT_DEQUEUE, 2'($urandom), 16'($urandom));
      end else begin
        n = $urandom_range(5, 30);
        repeat (n)
          send_word(($urandom_range(99) < 55) ? ACT_ENQUEUE : ACT_DEQUEUE,
                    2'($urandom), 16'($urandom));
      end
      if (!calm && $urandom_range(24) == 0) hold_requests++;
      if (!calm && $urandom_range(19) == 0) drain_results();
    end
    calm = 1'b0;

    drain_results();
    repeat (8) @(posedge clk);
    $display("%0d words sent: %0d enqueues, %0d dequeues, %0d with a bad level",
             words_sent, enqueues, dequeues, bad_levels);
    $display("%0d results checked, %0d refused on a full level, %0d reads of an empty queue",
             results_seen, full_rejects, empty_reads);
    if (error_count == 0 && pending == 0) begin
      $display("PASS strict_priority_event_queue");
    end else begin
      $display("FAIL strict_priority_event_queue");
    end
    $finish;
  end

endmodule
